FILE: rtl/core/agss_pkg.sv
// agss_pkg: types, constants and the control-word program for the arma-garch
// scenario step unit. The program table is read by agss top level sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package agss_pkg;

  localparam int unsigned PC_W = 6;
  localparam int unsigned SRC_N = 32;

  // configuration register indexes
  localparam logic [2:0] CFG_VAR_CONST  = 3'd0;
  localparam logic [2:0] CFG_ARCH_COEF  = 3'd1;
  localparam logic [2:0] CFG_GARCH_COEF = 3'd2;
  localparam logic [2:0] CFG_MEAN_CONST = 3'd3;
  localparam logic [2:0] CFG_AR_COEF    = 3'd4;
  localparam logic [2:0] CFG_MA_COEF    = 3'd5;

  // request action codes
  localparam logic [2:0] ACT_SIMULATE = 3'd0;
  localparam logic [2:0] ACT_CLEAR    = 3'd1;
  localparam logic [2:0] ACT_LOAD_STD = 3'd2;
  localparam logic [2:0] ACT_LOAD_SIG = 3'd3;
  localparam logic [2:0] ACT_LOAD_LVL = 3'd4;
  localparam logic [2:0] ACT_LOAD_SCL = 3'd5;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  // square root: radicand below 2^49, first trial bit 2^48
  localparam int unsigned SQ_W = 50;
  localparam int unsigned ACC_W = 35;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL,     // product register <= a * b
    OP_RND,     // dst <= round and saturate product
    OP_ADD,     // dst <= sat(a + b)
    OP_SUB,     // dst <= sat(a - b)
    OP_ACC,     // acc <= a + b, wide
    OP_ACCADD,  // acc <= acc + a, wide
    OP_SATACC,  // dst <= sat(acc)
    OP_SQRT,    // start root of max(acc, 0) * 2^16
    OP_WSQ,     // dst <= root once finished
    OP_DONE     // commit lags and result
  } op_e;

  typedef enum logic [4:0] {
    SRC_ONE, SRC_LSTD, SRC_LSIG, SRC_LLVL, SRC_LSCL,
    SRC_OMEGA, SRC_ARCH, SRC_GARCH, SRC_MCON, SRC_AR, SRC_MA,
    SRC_DRAW, SRC_SHIFT, SRC_MIXW, SRC_M1, SRC_M2, SRC_S1, SRC_S2,
    SRC_SV, SRC_UV,
    SRC_T0, SRC_T1, SRC_ZS, SRC_U1, SRC_U2, SRC_FC, SRC_SIG, SRC_ET, SRC_EP
  } src_e;

  typedef enum logic [3:0] {
    D_NONE, D_T0, D_T1, D_ZS, D_U1, D_U2, D_FC, D_SIG, D_ET, D_EP, D_LV
  } dst_e;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_SQ_BUSY,
    JC_OUT_FULL
  } jc_e;

  typedef struct packed {
    op_e             op;
    src_e            a;
    src_e            b;
    dst_e            dst;
    jc_e             jc;
    logic [PC_W-1:0] jt;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_WAIT_SQ = 6'd33;
  localparam logic [PC_W-1:0] PC_DONE    = 6'd39;

  function automatic ctrl_t cw(input op_e op, input src_e a, input src_e b,
                               input dst_e dst);
    ctrl_t c;
    c.op  = op;
    c.a   = a;
    c.b   = b;
    c.dst = dst;
    c.jc  = JC_NONE;
    c.jt  = '0;
    return c;
  endfunction

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = cw(OP_NOP, SRC_ONE, SRC_ONE, D_NONE);
    unique case (pc)
      // conditional variance
      6'd0:  c = cw(OP_MUL,    SRC_LSTD,  SRC_LSTD,  D_NONE);
      6'd1:  c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_T0);
      6'd2:  c = cw(OP_MUL,    SRC_ARCH,  SRC_T0,    D_NONE);
      6'd3:  c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_T0);
      6'd4:  c = cw(OP_MUL,    SRC_LSIG,  SRC_LSIG,  D_NONE);
      6'd5:  c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_T1);
      6'd6:  c = cw(OP_MUL,    SRC_GARCH, SRC_T1,    D_NONE);
      6'd7:  c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_T1);
      6'd8:  c = cw(OP_ACC,    SRC_OMEGA, SRC_T0,    D_NONE);
      6'd9:  c = cw(OP_ACCADD, SRC_T1,    SRC_ONE,   D_NONE);
      6'd10: c = cw(OP_SQRT,   SRC_ONE,   SRC_ONE,   D_NONE);
      // forecast, while the root runs
      6'd11: c = cw(OP_MUL,    SRC_AR,    SRC_LLVL,  D_NONE);
      6'd12: c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_T0);
      6'd13: c = cw(OP_MUL,    SRC_MA,    SRC_LSCL,  D_NONE);
      6'd14: c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_T1);
      6'd15: c = cw(OP_ACC,    SRC_MCON,  SRC_T0,    D_NONE);
      6'd16: c = cw(OP_ACCADD, SRC_T1,    SRC_ONE,   D_NONE);
      6'd17: c = cw(OP_SATACC, SRC_ONE,   SRC_ONE,   D_FC);
      // mixture
      6'd18: c = cw(OP_ADD,    SRC_DRAW,  SRC_SHIFT, D_ZS);
      6'd19: c = cw(OP_MUL,    SRC_S1,    SRC_ZS,    D_NONE);
      6'd20: c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_T0);
      6'd21: c = cw(OP_ADD,    SRC_M1,    SRC_T0,    D_U1);
      6'd22: c = cw(OP_MUL,    SRC_S2,    SRC_ZS,    D_NONE);
      6'd23: c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_T0);
      6'd24: c = cw(OP_ADD,    SRC_M2,    SRC_T0,    D_U2);
      6'd25: c = cw(OP_SUB,    SRC_ONE,   SRC_MIXW,  D_T1);
      6'd26: c = cw(OP_MUL,    SRC_U1,    SRC_MIXW,  D_NONE);
      6'd27: c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_T0);
      6'd28: c = cw(OP_MUL,    SRC_U2,    SRC_T1,    D_NONE);
      6'd29: c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_T1);
      6'd30: c = cw(OP_ADD,    SRC_T0,    SRC_T1,    D_U1);
      6'd31: c = cw(OP_MUL,    SRC_SV,    SRC_UV,    D_NONE);
      6'd32: c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_T0);
      6'd33: begin
        c = cw(OP_WSQ, SRC_ONE, SRC_ONE, D_SIG);
        c.jc = JC_SQ_BUSY;
        c.jt = PC_WAIT_SQ;
      end
      // shocks and level
      6'd34: c = cw(OP_MUL,    SRC_SIG,   SRC_U1,    D_NONE);
      6'd35: c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_ET);
      6'd36: c = cw(OP_MUL,    SRC_T0,    SRC_ET,    D_NONE);
      6'd37: c = cw(OP_RND,    SRC_ONE,   SRC_ONE,   D_EP);
      6'd38: c = cw(OP_ADD,    SRC_FC,    SRC_EP,    D_LV);
      6'd39: begin
        c = cw(OP_DONE, SRC_ONE, SRC_ONE, D_NONE);
        c.jc = JC_OUT_FULL;
        c.jt = PC_DONE;
      end
      default: c = cw(OP_NOP, SRC_ONE, SRC_ONE, D_NONE);
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/arma_garch_scenario_step_unit.sv
// arma_garch_scenario_step_unit: one ARMA(1,1)-GARCH(1,1) step per simulate
// request, run by a 40-step control program over one multiplier, one adder
// and a bit-serial square root. Depends on agss_pkg.
// A simulate request runs the control program to its end and loads the result
// register, later while a pending result is stalled; the next request is
// accepted in the cycle after, so a new simulate request waits for the last one.
// The run length is set by the 25-iteration root unit and the single multiplier.
// Clear and load requests are applied when accepted and give no result.
// Reset (rst_ni low, asynchronous) clears configuration, lags and control.
`timescale 1ns / 1ps
`default_nettype none

module arma_garch_scenario_step_unit
  import agss_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [2:0]         action_i,
  input  wire logic signed [31:0] draw_i,
  input  wire logic signed [31:0] draw_shift_i,
  input  wire logic signed [31:0] mix_weight_i,
  input  wire logic signed [31:0] mean_one_i,
  input  wire logic signed [31:0] mean_two_i,
  input  wire logic signed [31:0] spread_one_i,
  input  wire logic signed [31:0] spread_two_i,
  input  wire logic signed [31:0] seasonal_vol_i,
  input  wire logic signed [31:0] uncond_vol_i,
  input  wire logic signed [31:0] history_value_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [31:0] shifted_draw_o,
  output      logic [30:0]        cond_sigma_o,
  output      logic signed [31:0] std_shock_o,
  output      logic signed [31:0] scaled_shock_o,
  output      logic signed [31:0] level_o,
  output      logic signed [31:0] level_forecast_o
);

  // configuration
  logic [30:0]        omega_q;
  logic signed [31:0] arch_q, garch_q, mcon_q, ar_q, ma_q;

  // history
  logic signed [31:0] lstd_q, lsig_q, llvl_q, lscl_q;

  // captured request
  logic signed [31:0] draw_q, shift_q, mixw_q, m1_q, m2_q, s1_q, s2_q, sv_q, uv_q;

  // working registers
  logic signed [31:0] t0_q, t1_q, zs_q, u1_q, u2_q, fc_q, sig_q, et_q, ep_q, lv_q;
  logic signed [31:0] dst_val;
  logic signed [63:0] prod_q, prod_d, rnd;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  // square root unit
  logic [SQ_W-1:0] sq_rem_q, sq_res_q, sq_bit_q, sq_trial;
  logic            sq_busy, sq_start;

  // sequencer
  state_e          state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           ctl;
  logic            hold, run, commit, wr_en;
  logic            in_fire, out_fire, out_valid_q;

  logic signed [31:0] src_val [SRC_N];
  logic signed [31:0] opa, opb;

  logic signed [31:0] o_sd_q, o_et_q, o_ep_q, o_lv_q, o_fc_q;
  logic [30:0]        o_sig_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  assign run = (state_q == ST_RUN);
  assign ctl = ucode(pc_q);

  // operand selection
  always_comb begin
    for (int i = 0; i < SRC_N; i++) begin
      src_val[i] = '0;
    end
    src_val[SRC_ONE]   = Q_ONE;
    src_val[SRC_LSTD]  = lstd_q;
    src_val[SRC_LSIG]  = lsig_q;
    src_val[SRC_LLVL]  = llvl_q;
    src_val[SRC_LSCL]  = lscl_q;
    src_val[SRC_OMEGA] = $signed({1'b0, omega_q});
    src_val[SRC_ARCH]  = arch_q;
    src_val[SRC_GARCH] = garch_q;
    src_val[SRC_MCON]  = mcon_q;
    src_val[SRC_AR]    = ar_q;
    src_val[SRC_MA]    = ma_q;
    src_val[SRC_DRAW]  = draw_q;
    src_val[SRC_SHIFT] = shift_q;
    src_val[SRC_MIXW]  = mixw_q;
    src_val[SRC_M1]    = m1_q;
    src_val[SRC_M2]    = m2_q;
    src_val[SRC_S1]    = s1_q;
    src_val[SRC_S2]    = s2_q;
    src_val[SRC_SV]    = sv_q;
    src_val[SRC_UV]    = uv_q;
    src_val[SRC_T0]    = t0_q;
    src_val[SRC_T1]    = t1_q;
    src_val[SRC_ZS]    = zs_q;
    src_val[SRC_U1]    = u1_q;
    src_val[SRC_U2]    = u2_q;
    src_val[SRC_FC]    = fc_q;
    src_val[SRC_SIG]   = sig_q;
    src_val[SRC_ET]    = et_q;
    src_val[SRC_EP]    = ep_q;
  end

  assign opa = src_val[ctl.a];
  assign opb = src_val[ctl.b];

  // conditional jumps
  always_comb begin
    unique case (ctl.jc)
      JC_SQ_BUSY:  hold = sq_busy;
      JC_OUT_FULL: hold = out_valid_q && out_stall_i;
      default:     hold = 1'b0;
    endcase
  end

  assign commit   = run && (ctl.op == OP_DONE) && !hold;
  assign sq_start = run && (ctl.op == OP_SQRT);

  // datapath: product, accumulator and writeback value
  assign rnd = prod_q + 64'sd32768;

  always_comb begin
    prod_d  = prod_q;
    acc_d   = acc_q;
    dst_val = '0;
    wr_en   = 1'b0;
    unique case (ctl.op)
      OP_MUL: prod_d = 64'(opa) * 64'(opb);
      OP_RND: begin
        dst_val = sat32(rnd >>> 16);
        wr_en   = 1'b1;
      end
      OP_ADD: begin
        dst_val = sat32(64'(opa) + 64'(opb));
        wr_en   = 1'b1;
      end
      OP_SUB: begin
        dst_val = sat32(64'(opa) - 64'(opb));
        wr_en   = 1'b1;
      end
      OP_ACC:    acc_d = ACC_W'(opa) + ACC_W'(opb);
      OP_ACCADD: acc_d = acc_q + ACC_W'(opa);
      OP_SATACC: begin
        dst_val = sat32(64'(acc_q));
        wr_en   = 1'b1;
      end
      OP_WSQ: begin
        dst_val = $signed({1'b0, sq_res_q[30:0]});
        wr_en   = !sq_busy;
      end
      default: begin
        dst_val = '0;
        wr_en   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (run) begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
      if (wr_en) begin
        unique case (ctl.dst)
          D_T0:    t0_q  <= dst_val;
          D_T1:    t1_q  <= dst_val;
          D_ZS:    zs_q  <= dst_val;
          D_U1:    u1_q  <= dst_val;
          D_U2:    u2_q  <= dst_val;
          D_FC:    fc_q  <= dst_val;
          D_SIG:   sig_q <= dst_val;
          D_ET:    et_q  <= dst_val;
          D_EP:    ep_q  <= dst_val;
          D_LV:    lv_q  <= dst_val;
          default: t0_q  <= t0_q;
        endcase
      end
    end
  end

  // bit-serial square root, two radicand bits per cycle
  assign sq_busy  = |sq_bit_q;
  assign sq_trial = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_bit_q <= '0;
    end else if (sq_start) begin
      sq_bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (sq_busy) begin
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_start) begin
      sq_rem_q <= acc_q[ACC_W-1] ? '0 : {acc_q[ACC_W-2:0], 16'b0};
      sq_res_q <= '0;
    end else if (sq_busy) begin
      if (sq_rem_q >= sq_trial) begin
        sq_rem_q <= sq_rem_q - sq_trial;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && action_i == ACT_SIMULATE) begin
          state_d = ST_RUN;
          pc_d    = '0;
        end
      end
      ST_RUN: begin
        if (hold) begin
          pc_d = ctl.jt;
        end else if (ctl.op == OP_DONE) begin
          state_d = ST_IDLE;
          pc_d    = '0;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
        pc_d    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_q <= '0;
      arch_q  <= '0;
      garch_q <= '0;
      mcon_q  <= '0;
      ar_q    <= '0;
      ma_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VAR_CONST:  omega_q <= cfg_wdata_i[30:0];
        CFG_ARCH_COEF:  arch_q  <= cfg_wdata_i;
        CFG_GARCH_COEF: garch_q <= cfg_wdata_i;
        CFG_MEAN_CONST: mcon_q  <= cfg_wdata_i;
        CFG_AR_COEF:    ar_q    <= cfg_wdata_i;
        CFG_MA_COEF:    ma_q    <= cfg_wdata_i;
        default:        omega_q <= omega_q;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_fire && action_i == ACT_SIMULATE) begin
      draw_q  <= draw_i;
      shift_q <= draw_shift_i;
      mixw_q  <= mix_weight_i;
      m1_q    <= mean_one_i;
      m2_q    <= mean_two_i;
      s1_q    <= spread_one_i;
      s2_q    <= spread_two_i;
      sv_q    <= seasonal_vol_i;
      uv_q    <= uncond_vol_i;
    end
  end

  // history: loaded and cleared on request, updated when a step commits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lstd_q <= '0;
      lsig_q <= '0;
      llvl_q <= '0;
      lscl_q <= '0;
    end else if (commit) begin
      lstd_q <= et_q;
      lsig_q <= sig_q;
      llvl_q <= lv_q;
      lscl_q <= ep_q;
    end else if (in_fire) begin
      case (action_i)
        ACT_CLEAR: begin
          lstd_q <= '0;
          lsig_q <= '0;
          llvl_q <= '0;
          lscl_q <= '0;
        end
        ACT_LOAD_STD: lstd_q <= history_value_i;
        ACT_LOAD_SIG: lsig_q <= history_value_i;
        ACT_LOAD_LVL: llvl_q <= history_value_i;
        ACT_LOAD_SCL: lscl_q <= history_value_i;
        default:      lstd_q <= lstd_q;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      o_sd_q  <= zs_q;
      o_sig_q <= sig_q[30:0];
      o_et_q  <= et_q;
      o_ep_q  <= ep_q;
      o_lv_q  <= lv_q;
      o_fc_q  <= fc_q;
    end
  end

  assign shifted_draw_o   = o_sd_q;
  assign cond_sigma_o     = o_sig_q;
  assign std_shock_o      = o_et_q;
  assign scaled_shock_o   = o_ep_q;
  assign level_o          = o_lv_q;
  assign level_forecast_o = o_fc_q;

  // checks
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && action_i == ACT_SIMULATE |=> state_q == ST_RUN && pc_q == '0)
    else $error("simulate request did not start the program");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> !out_valid_q || !out_stall_i)
    else $error("result committed over a pending result");

  a_root_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_busy)
    else $error("root started while busy");

  a_sigma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> o_sig_q[30:25] == '0)
    else $error("sigma out of range");

endmodule

`default_nettype wire
